// ===== rtl/smc_pkg.sv =====
// shared types, codes and helper functions of the stepper move controller
package smc_pkg;

  // opcodes carried in the input tuser
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // stored move kind
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FWD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd4;

  localparam logic [7:0] THRESH_RESET = 8'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIN
  } smc_state_t;

  // direction levels: bit 0 left motor, bit 1 right motor
  function automatic logic [1:0] dir_of_kind(input logic [KIND_W-1:0] kind);
    logic [1:0] lv;
    case (kind)
      KIND_FWD:   lv = 2'b11;
      KIND_BACK:  lv = 2'b00;
      KIND_RIGHT: lv = 2'b01;
      default:    lv = 2'b10;
    endcase
    return lv;
  endfunction

  function automatic logic is_straight(input logic [KIND_W-1:0] kind);
    return (kind == KIND_FWD) || (kind == KIND_BACK);
  endfunction

endpackage

// ===== rtl/stepper_move_controller.sv =====
// top level of the two-motor constant-rate stepper move controller
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser opcode, tdata move fields
//  out_    | out | out_tvalid/out_tready| tdata one status beat per input beat
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data obstacle threshold in cm
//
// a tick beat that may step passes through the bit-serial interval divider
// between the evaluation and finish states; every other beat goes from
// evaluation straight to the finish state
// rst_n is synchronous and active low; the threshold resets to 7 cm
// the input is not ready while a beat is in work; a finished beat waits in
// the output register, and the next input beat is taken meanwhile
module stepper_move_controller
  import smc_pkg::*;
#(
  parameter int TICKS_PER_SECOND = 1000000,
  parameter int STEP_COUNT_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] opcode
  input  logic [1:0]  in_tuser,
  // [23:0] move_steps, [39:24] move_rate, [41:40] move_kind, [51:42] range_cm
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] step_pulse, [1] left_dir, [2] right_dir, [3] busy_res, [4] paused,
  // [5] finished
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int SCB   = STEP_COUNT_BITS;
  localparam int NUM_W = $clog2(TICKS_PER_SECOND + 1);
  localparam logic [NUM_W-1:0] TPS_NUM = NUM_W'(TICKS_PER_SECOND);

  // ---- sequencer ----
  smc_state_t state_r, state_nxt;

  // latched input beat
  logic [1:0]  opc_r;
  logic [23:0] steps_r;
  logic [15:0] rate_r;
  logic [1:0]  kind_r;
  logic [9:0]  range_r;

  // move state
  logic [31:0]       clock_us_r, clock_us_nxt;
  logic [31:0]       last_step_r, last_step_nxt;
  logic [SCB-1:0]    target_r, target_nxt;
  logic [SCB-1:0]    done_cnt_r, done_cnt_nxt;
  logic [15:0]       act_rate_r, act_rate_nxt;
  logic [15:0]       sav_rate_r, sav_rate_nxt;
  logic              motion_r, motion_nxt;
  logic [KIND_W-1:0] kind_st_r, kind_st_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [7:0]        thr_r;

  logic       out_valid_r;
  logic [7:0] out_data_r, out_data_nxt;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_quo;
  logic             commit, out_free, step_ok;

  // a tick steps only with a rate and steps left
  assign step_ok  = (act_rate_r != 16'd0) && (done_cnt_r < target_r);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // interval divider: TICKS_PER_SECOND / active rate
  smc_div #(
    .NUM_W(NUM_W),
    .DEN_W(16)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (TPS_NUM),
    .den  (act_rate_r),
    .done (div_done),
    .quo  (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    commit    = 1'b0;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EVAL;
      S_EVAL: begin
        if (opc_r == OP_TICK && step_ok) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV:  if (div_done) state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- state update of one beat ----
  logic [31:0]       clk_inc;
  logic [31:0]       interval;
  logic              pulse, fin, obstacle;
  logic [SCB-1:0]    remain;
  logic [KIND_W-1:0] start_kind;

  assign clk_inc    = clock_us_r + 32'd1;
  assign interval   = 32'(div_quo);
  assign remain     = target_r - done_cnt_r;
  assign start_kind = {1'b0, kind_r} + KIND_W'(1);
  assign obstacle   = (range_r != 10'd0) && (range_r < {2'b00, thr_r});

  always_comb begin
    clock_us_nxt = clock_us_r;
    last_step_nxt = last_step_r;
    target_nxt   = target_r;
    done_cnt_nxt = done_cnt_r;
    act_rate_nxt = act_rate_r;
    sav_rate_nxt = sav_rate_r;
    motion_nxt   = motion_r;
    kind_st_nxt  = kind_st_r;
    dir_nxt      = dir_r;
    pulse        = 1'b0;
    fin          = 1'b0;
    case (opc_r)
      OP_TICK: begin
        clock_us_nxt = clk_inc;
        if (step_ok && (clk_inc - last_step_r >= interval)) begin
          pulse         = 1'b1;
          last_step_nxt = clk_inc;
          done_cnt_nxt  = done_cnt_r + SCB'(1);
        end
        if (motion_r && (done_cnt_nxt >= target_r)) begin
          act_rate_nxt = 16'd0;
          motion_nxt   = 1'b0;
          fin          = 1'b1;
        end
      end
      OP_START: begin
        target_nxt   = SCB'(steps_r);
        done_cnt_nxt = '0;
        act_rate_nxt = rate_r;
        motion_nxt   = 1'b1;
        kind_st_nxt  = start_kind;
        dir_nxt      = dir_of_kind(start_kind);
      end
      OP_RANGE: begin
        // rotations ignore range readings
        if (kind_st_r != KIND_RIGHT && kind_st_r != KIND_LEFT) begin
          if (obstacle) begin
            if (act_rate_r != 16'd0) begin
              sav_rate_nxt = act_rate_r;
              act_rate_nxt = 16'd0;
            end
          end else if (act_rate_r == 16'd0 && motion_r && is_straight(kind_st_r)) begin
            // resume with the steps that remain
            target_nxt   = remain;
            done_cnt_nxt = '0;
            act_rate_nxt = sav_rate_r;
            dir_nxt      = dir_of_kind(kind_st_r);
          end
        end
      end
      default: begin
        // stop keeps counts and direction levels
        act_rate_nxt = 16'd0;
        motion_nxt   = 1'b0;
        kind_st_nxt  = KIND_STOP;
      end
    endcase
    out_data_nxt = {2'b00, fin,
                    motion_nxt && (act_rate_nxt == 16'd0) && is_straight(kind_st_nxt),
                    motion_nxt, dir_nxt[1], dir_nxt[0], pulse};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_us_r  <= '0;
      last_step_r <= '0;
      target_r    <= '0;
      done_cnt_r  <= '0;
      act_rate_r  <= '0;
      sav_rate_r  <= '0;
      motion_r    <= 1'b0;
      kind_st_r   <= KIND_STOP;
      dir_r       <= '0;
      thr_r       <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) thr_r <= cfg_data;
      if (commit) begin
        clock_us_r  <= clock_us_nxt;
        last_step_r <= last_step_nxt;
        target_r    <= target_nxt;
        done_cnt_r  <= done_cnt_nxt;
        act_rate_r  <= act_rate_nxt;
        sav_rate_r  <= sav_rate_nxt;
        motion_r    <= motion_nxt;
        kind_st_r   <= kind_st_nxt;
        dir_r       <= dir_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (commit) out_data_r <= out_data_nxt;
    // capture the accepted beat
    if (in_tvalid && in_tready) begin
      opc_r   <= in_tuser;
      steps_r <= in_tdata[23:0];
      rate_r  <= in_tdata[39:24];
      kind_r  <= in_tdata[41:40];
      range_r <= in_tdata[51:42];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- checks ----
  a_rate_needs_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (act_rate_r != 16'd0) |-> motion_r)
    else $error("nonzero rate without a move in progress");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_fin_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[5] && out_data_r[3]))
    else $error("finished beat still reports busy");

  a_paused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[4]) |-> out_data_r[3])
    else $error("paused without a move in progress");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EVAL))
    else $error("accepted beat did not enter evaluation");

endmodule

// ===== rtl/smc_div.sv =====
// restoring divider, one quotient bit per cycle
module smc_div
  import smc_pkg::*;
#(
  parameter int NUM_W = 20,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(NUM_W);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W+1:0] trial;
  logic             ge;

  // shift in the next dividend bit and try the subtract
  assign trial = {1'b0, rem_r, quo_r[NUM_W-1]} - {2'b00, den};
  assign ge    = !trial[DEN_W+1];

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_INIT;
      rem_nxt = '0;
      quo_nxt = num;
    end else if (run_r) begin
      rem_nxt = ge ? trial[DEN_W-1:0] : {rem_r[DEN_W-2:0], quo_r[NUM_W-1]};
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== test/tb_top.sv =====
// self-checking bench for the stepper move controller: opening table plus random move sequences
`timescale 1ns / 1ps

module tb_top
  import smc_pkg::*;
();

  localparam int WATCHDOG_LIMIT   = 4000; // quiet cycles before the run is declared hung
  localparam int LONG_HOLD_CYCLES = 400;  // one long receiver hold-off to back up the block
  localparam int DRAIN_CYCLES     = 60;   // settle time after the last status beat
  localparam int PHASE_BEATS      = 200;  // random beats per threshold setting
  localparam int NUM_PHASES       = 6;

  // one status beat, last field in the lowest bit as on out_tdata
  typedef struct packed {
    logic finished;
    logic paused;
    logic busy;
    logic right_dir;
    logic left_dir;
    logic step_pulse;
  } status_t;

  // per input beat: optional hand-written status that replaces the prediction
  typedef struct packed {
    bit      has_fixed;
    status_t fixed;
  } beat_note_t;

  // one row of the opening table
  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] steps;
    logic [15:0] rate;
    logic [1:0]  kind;
    logic [9:0]  range_cm;
    int          reps;
    bit          has_fixed;
    status_t     fixed;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = OP_TICK;  // [1:0] opcode
  // [23:0] move_steps, [39:24] move_rate, [41:40] move_kind, [51:42] range_cm
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] step_pulse, [1] left_dir, [2] right_dir, [3] busy_res, [4] paused, [5] finished
  logic [7:0]  out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // controller image kept by the bench
  logic [7:0]        obstacle_thr = THRESH_RESET;
  logic [31:0]       clock_us = '0;
  logic [31:0]       last_step_us = '0;
  logic [23:0]       target_count = '0;
  logic [23:0]       done_count = '0;
  logic [15:0]       active_rate = '0;
  logic [15:0]       saved_rate = '0;
  logic              in_motion = 1'b0;
  logic [KIND_W-1:0] last_kind = KIND_STOP;
  logic [1:0]        dir_levels = 2'b00;  // bit 0 left motor, bit 1 right motor

  status_t    pending_status_q[$];  // predicted status beats not yet seen
  beat_note_t beat_note_q[$];       // notes of beats offered, in order
  plan_row_t  opening_plan[$];

  int fail_count = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;          // random gaps on both sides
  bit long_hold_req = 1'b0;    // ask the receiver for one long hold-off

  stepper_move_controller u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // move predictor
  // ---------------------------------------------------------------------------

  // load a new move; also used when a clear reading resumes a paused one
  function automatic void load_move(input logic [23:0] steps, input logic [15:0] rate,
                                    input logic [KIND_W-1:0] kind);
    target_count = steps;
    done_count   = '0;
    active_rate  = rate;
    in_motion    = 1'b1;
    last_kind    = kind;
    case (kind)
      KIND_FWD:   dir_levels = 2'b11;
      KIND_BACK:  dir_levels = 2'b00;
      KIND_RIGHT: dir_levels = 2'b01;
      default:    dir_levels = 2'b10;
    endcase
  endfunction

  // advance the image by one input beat and return the status beat it causes
  function automatic status_t advance_motion(input logic [1:0] op, input logic [55:0] d);
    logic [23:0]       steps;
    logic [15:0]       rate;
    logic [1:0]        kind;
    logic [9:0]        range_cm;
    logic [31:0]       interval;
    logic              straight;
    logic              rotating;
    status_t           st;
    steps    = d[23:0];
    rate     = d[39:24];
    kind     = d[41:40];
    range_cm = d[51:42];
    st       = '0;
    rotating = (last_kind == KIND_RIGHT) || (last_kind == KIND_LEFT);
    straight = (last_kind == KIND_FWD) || (last_kind == KIND_BACK);
    case (op)
      OP_TICK: begin
        clock_us = clock_us + 32'd1;
        if (active_rate != '0 && done_count < target_count) begin
          interval = 32'd1000000 / {16'd0, active_rate};
          // elapsed time wraps modulo 2^32
          if (clock_us - last_step_us >= interval) begin
            st.step_pulse = 1'b1;
            last_step_us  = clock_us;
            done_count    = done_count + 24'd1;
          end
        end
        if (in_motion && done_count >= target_count) begin
          active_rate = '0;
          in_motion   = 1'b0;
          st.finished = 1'b1;
        end
      end
      OP_START: load_move(steps, rate, {1'b0, kind} + 3'd1);
      OP_RANGE: begin
        // readings are ignored while turning
        if (!rotating) begin
          if (range_cm != '0 && range_cm < {2'b00, obstacle_thr}) begin
            if (active_rate != '0) begin
              saved_rate  = active_rate;
              active_rate = '0;
            end
          end else if (active_rate == '0 && in_motion && straight) begin
            load_move(target_count - done_count, saved_rate, last_kind);
          end
        end
      end
      default: begin
        // stop keeps counts and direction levels
        active_rate = '0;
        in_motion   = 1'b0;
        last_kind   = KIND_STOP;
      end
    endcase
    st.left_dir  = dir_levels[0];
    st.right_dir = dir_levels[1];
    st.busy      = in_motion;
    st.paused    = in_motion && active_rate == '0 &&
                   (last_kind == KIND_FWD || last_kind == KIND_BACK);
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  function automatic logic [55:0] move_fields(input logic [23:0] steps, input logic [15:0] rate,
                                              input logic [1:0] kind, input logic [9:0] range_cm);
    return {4'b0000, range_cm, kind, rate, steps};
  endfunction

  // status with no step pulse, for hand-written rows; bits are l r busy paused fin, l first
  function automatic status_t status_of(input logic [4:0] lrbpf);
    status_t st;
    st = '0;
    st.left_dir  = lrbpf[4];
    st.right_dir = lrbpf[3];
    st.busy      = lrbpf[2];
    st.paused    = lrbpf[1];
    st.finished  = lrbpf[0];
    return st;
  endfunction

  // distances below and at the current threshold, plus zero, the maximum and random ones
  function automatic logic [9:0] pick_range_cm();
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return (obstacle_thr > 8'd1) ? 10'($urandom_range(1, obstacle_thr - 8'd1)) : 10'd1;
      2: return {2'b00, obstacle_thr};
      3: return 10'd1023;
      default: return 10'($urandom);
    endcase
  endfunction

  task automatic report_status_error(input string what, input status_t want,
                                     input status_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: want pulse=%b l=%b r=%b busy=%b paused=%b fin=%b",
               $time, what, want.step_pulse, want.left_dir, want.right_dir, want.busy,
               want.paused, want.finished);
      $display("    got pulse=%b l=%b r=%b busy=%b paused=%b fin=%b",
               got.step_pulse, got.left_dir, got.right_dir, got.busy, got.paused,
               got.finished);
    end
  endtask

  task automatic add_row(input logic [1:0] op, input logic [23:0] steps, input logic [15:0] rate,
                         input logic [1:0] kind, input logic [9:0] range_cm, input int reps,
                         input bit has_fixed, input status_t fixed);
    plan_row_t row;
    row.op        = op;
    row.steps     = steps;
    row.rate      = rate;
    row.kind      = kind;
    row.range_cm  = range_cm;
    row.reps      = reps;
    row.has_fixed = has_fixed;
    row.fixed     = fixed;
    opening_plan.push_back(row);
  endtask

  // offer one input beat, sometimes after a random gap, and hold it until taken
  task automatic send_beat(input logic [1:0] op, input logic [55:0] data, input bit has_fixed,
                           input status_t fixed);
    int         gap;
    beat_note_t note;
    note.has_fixed = has_fixed;
    note.fixed     = fixed;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat_note_q.push_back(note);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // wait until every predicted status is out, then write the threshold
  task automatic write_threshold(input logic [7:0] thr);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_status_q.size() != 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    obstacle_thr  = thr;
  endtask

  // one move: a start beat, then mostly ticks with readings, stops and noise mixed in
  task automatic run_move_episode();
    logic [23:0] steps;
    logic [15:0] rate;
    logic [1:0]  kind;
    int          n_ticks;
    int          i;
    int          sel;
    kind = ($urandom_range(0, 3) != 0) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
    sel = $urandom_range(0, 19);
    if (sel == 0)      steps = 24'($urandom);
    else if (sel == 1) steps = 24'hFFFFFF;
    else               steps = 24'($urandom_range(0, 6));
    sel = $urandom_range(0, 19);
    if (sel == 0)      rate = 16'd0;
    else if (sel == 1) rate = 16'($urandom);
    else               rate = 16'($urandom_range(16000, 65535));
    send_beat(OP_START, move_fields(steps, rate, kind, 10'($urandom)), 1'b0, '0);
    n_ticks = $urandom_range(10, 200);
    for (i = 0; i < n_ticks; i++) begin
      sel = $urandom_range(0, 99);
      // unused fields carry random bits on every beat
      if (sel < 85)
        send_beat(OP_TICK, move_fields(24'($urandom), 16'($urandom), 2'($urandom),
                                       10'($urandom)), 1'b0, '0);
      else if (sel < 97)
        send_beat(OP_RANGE, move_fields(24'($urandom), 16'($urandom), 2'($urandom),
                                        pick_range_cm()), 1'b0, '0);
      else if (sel < 98)
        send_beat(OP_STOP, move_fields(24'($urandom), 16'($urandom), 2'($urandom),
                                       10'($urandom)), 1'b0, '0);
      else
        send_beat(2'($urandom), move_fields(24'($urandom), 16'($urandom), 2'($urandom),
                                            10'($urandom)), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitors
  // ---------------------------------------------------------------------------

  // every accepted input beat moves the image and queues one status beat
  always @(posedge clk) begin : input_mon
    status_t    st;
    beat_note_t note;
    if (rst_n && in_tvalid && in_tready) begin
      st = advance_motion(in_tuser, in_tdata);
      note = beat_note_q.pop_front();
      pending_status_q.push_back(note.has_fixed ? note.fixed : st);
    end
  end

  // every accepted status beat is checked against the oldest prediction
  always @(posedge clk) begin : status_mon
    status_t got;
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = status_t'(out_tdata[5:0]);
      if (pending_status_q.size() == 0) begin
        report_status_error("status beat with none pending", '0, got);
      end else begin
        want = pending_status_q.pop_front();
        if (got !== want)
          report_status_error("status mismatch", want, got);
      end
    end
  end

  // hang detection: cycles in which no channel moves a beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver pacing
  // ---------------------------------------------------------------------------

  initial begin : sink_pacing
    int n;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        // long hold-off while the sender keeps offering, so the block backs up
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 24);
        repeat (n) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int         i;
    int         k;
    int         ph;
    int         phase_end;
    logic [7:0] thr;
    plan_row_t  row;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening table at the reset threshold of 7 cm
    // op        steps         rate       kind  range  reps fixed  status (l r busy paused fin)
    add_row(OP_TICK,  24'd0,        16'd0,     2'd0, 10'd0,    1,  1'b1, status_of(5'b00000));
    // obstacle while idle does nothing
    add_row(OP_RANGE, 24'd0,        16'd0,     2'd0, 10'd3,    1,  1'b1, status_of(5'b00000));
    add_row(OP_START, 24'd0,        16'd1000,  2'd0, 10'd0,    1,  1'b1, status_of(5'b11100));
    // zero step count ends on the next tick without a pulse
    add_row(OP_TICK,  24'd0,        16'd0,     2'd0, 10'd0,    1,  1'b1, status_of(5'b11001));
    add_row(OP_START, 24'd1,        16'd65535, 2'd1, 10'd0,    1,  1'b1, status_of(5'b00100));
    // obstacle pauses a straight move, zero range counts as clear and resumes it
    add_row(OP_RANGE, 24'd0,        16'd0,     2'd0, 10'd1,    1,  1'b1, status_of(5'b00110));
    add_row(OP_RANGE, 24'd0,        16'd0,     2'd0, 10'd0,    1,  1'b1, status_of(5'b00100));
    // fastest rate: pulse once 15 ticks have passed since the last one, then finish
    add_row(OP_TICK,  24'd0,        16'd0,     2'd0, 10'd0,   14,  1'b0, '0);
    add_row(OP_START, 24'hFFFFFF,   16'd65535, 2'd2, 10'd0,    1,  1'b1, status_of(5'b10100));
    // readings are ignored while turning
    add_row(OP_RANGE, 24'd0,        16'd0,     2'd0, 10'd2,    1,  1'b1, status_of(5'b10100));
    add_row(OP_TICK,  24'd0,        16'd0,     2'd0, 10'd0,    1,  1'b0, '0);
    // stop keeps the direction levels
    add_row(OP_STOP,  24'd0,        16'd0,     2'd0, 10'd0,    1,  1'b1, status_of(5'b10000));
    // zero rate turn is busy but not paused
    add_row(OP_START, 24'd3,        16'd0,     2'd3, 10'd0,    1,  1'b1, status_of(5'b01100));
    add_row(OP_RANGE, 24'd0,        16'd0,     2'd0, 10'd1023, 1,  1'b0, '0);
    // zero rate straight move reads as paused; clear starts it at the saved rate
    add_row(OP_START, 24'd2,        16'd0,     2'd0, 10'd0,    1,  1'b1, status_of(5'b11110));
    add_row(OP_RANGE, 24'd0,        16'd0,     2'd0, 10'd0,    1,  1'b0, '0);
    add_row(OP_TICK,  24'd0,        16'd0,     2'd0, 10'd0,    1,  1'b0, '0);
    add_row(OP_STOP,  24'd0,        16'd0,     2'd0, 10'd0,    1,  1'b1, status_of(5'b11000));
    add_row(OP_TICK,  24'd0,        16'd0,     2'd0, 10'd0,    1,  1'b0, '0);

    for (i = 0; i < opening_plan.size(); i++) begin
      row = opening_plan[i];
      for (k = 0; k < row.reps; k++)
        send_beat(row.op, move_fields(row.steps, row.rate, row.kind, row.range_cm),
                  row.has_fixed, row.fixed);
    end

    // random phases, each under its own threshold, extremes first
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        3:       thr = 8'd1;
        default: thr = 8'($urandom);
      endcase
      write_threshold(thr);
      if (ph == 2)
        long_hold_req = 1'b1;
      // last phase runs with no gaps on either side
      if (ph == NUM_PHASES - 1)
        idle_on = 1'b0;
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end)
        run_move_episode();
    end

    // drain and let any stray beat show up
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_status_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    fail_count += pending_status_q.size();

    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
